/* design/rlcph_pkg.sv */
// Shared types and constants of the radio link control PDU header parser.
package rlcph_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int TDATA_W     = 48;
    localparam int BUF_W       = 9;

    typedef enum logic [1:0] {
        MODE_AM   = 2'd0,
        MODE_UM5  = 2'd1,
        MODE_UM10 = 2'd2,
        MODE_TM   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_HDR   = 3'd0,
        KIND_LI    = 3'd1,
        KIND_ACK   = 3'd2,
        KIND_NACK  = 3'd3,
        KIND_PAY   = 3'd4,
        KIND_END   = 3'd5,
        KIND_TRUNC = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_AMD_HDR  = 3'd1,
        PH_AMC_HDR  = 3'd2,
        PH_UM10_HDR = 3'd3,
        PH_EXT      = 3'd4,
        PH_NACK     = 3'd5,
        PH_PAYLOAD  = 3'd6,
        PH_TAIL     = 3'd7
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic        eop;
        logic [9:0]  sn;
        logic [1:0]  fi;
        logic        ext;
        logic        rf;
        logic        poll;
        logic [10:0] li;
        logic [9:0]  ssn;
        logic [7:0]  pay;
    } rec_t;

endpackage

/* design/rlcph_front.sv */
// Front end: takes PDU words, tracks the header parse and builds records.
module rlcph_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_data,
    input  logic                in_accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                rec_valid,
    output rlcph_pkg::rec_t     rec
);
    import rlcph_pkg::*;

    mode_t              mode_reg;
    phase_t             phase_reg, phase_next;
    logic [BUF_W-1:0]   bitbuf_reg, bitbuf_next;
    logic [3:0]         held_reg, held_next;
    logic [7:0]         hold_reg, hold_next;

    logic [15:0]        hdr_word;
    logic [16:0]        pushed;
    logic [4:0]         cnt;
    logic [4:0]         grp_shift;
    logic [11:0]        grp;
    logic [16:0]        keep_mask;
    logic               grp_done;
    logic               have;
    rec_t               r;

    always_comb
    begin
        hdr_word  = {hold_reg, in_byte};
        pushed    = {bitbuf_reg, in_byte};
        cnt       = {1'b0, held_reg} + 5'd8;
        grp_done  = (cnt >= 5'd12);
        grp_shift = cnt - 5'd12;
        grp       = 12'(pushed >> grp_shift);
        keep_mask = (17'd1 << grp_shift) - 17'd1;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        bitbuf_next = bitbuf_reg;
        held_next   = held_reg;
        hold_next   = hold_reg;
        r           = '0;
        have        = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                unique case (mode_reg)
                    MODE_AM:
                    begin
                        hold_next  = in_byte;
                        phase_next = in_byte[7] ? PH_AMD_HDR : PH_AMC_HDR;
                    end
                    MODE_UM5:
                    begin
                        r.kind      = KIND_HDR;
                        r.sn        = {5'd0, in_byte[4:0]};
                        r.fi        = in_byte[7:6];
                        r.ext       = in_byte[5];
                        have        = 1'b1;
                        bitbuf_next = '0;
                        held_next   = '0;
                        phase_next  = in_byte[5] ? PH_EXT : PH_PAYLOAD;
                    end
                    MODE_UM10:
                    begin
                        hold_next  = in_byte;
                        phase_next = PH_UM10_HDR;
                    end
                    default:
                    begin
                        r.kind     = KIND_PAY;
                        r.pay      = in_byte;
                        have       = 1'b1;
                        phase_next = PH_PAYLOAD;
                    end
                endcase
            end
            PH_AMD_HDR, PH_UM10_HDR:
            begin
                r.kind      = KIND_HDR;
                r.sn        = hdr_word[9:0];
                r.fi        = hdr_word[12:11];
                r.ext       = hdr_word[10];
                // RF and P exist only in the acknowledged data header.
                if (phase_reg == PH_AMD_HDR)
                begin
                    r.rf   = hdr_word[14];
                    r.poll = hdr_word[13];
                end
                have        = 1'b1;
                bitbuf_next = '0;
                held_next   = '0;
                phase_next  = hdr_word[10] ? PH_EXT : PH_PAYLOAD;
            end
            PH_AMC_HDR:
            begin
                r.kind      = KIND_ACK;
                r.ssn       = hdr_word[11:2];
                have        = 1'b1;
                bitbuf_next = {{(BUF_W-1){1'b0}}, hdr_word[0]};
                held_next   = 4'd1;
                phase_next  = hdr_word[1] ? PH_NACK : PH_TAIL;
            end
            PH_EXT, PH_NACK:
            begin
                if (grp_done)
                begin
                    have = 1'b1;
                    if (phase_reg == PH_EXT)
                    begin
                        r.kind = KIND_LI;
                        r.li   = grp[10:0];
                    end
                    else
                    begin
                        r.kind = KIND_NACK;
                        r.ssn  = grp[11:2];
                    end
                    // The more-groups flag is E for a length indicator, E1 for a NACK.
                    if ((phase_reg == PH_EXT) ? grp[11] : grp[1])
                    begin
                        bitbuf_next = BUF_W'(pushed & keep_mask);
                        held_next   = grp_shift[3:0];
                    end
                    else
                    begin
                        // Leftover bits are the pad or the ignored status tail.
                        bitbuf_next = '0;
                        held_next   = '0;
                        phase_next  = (phase_reg == PH_EXT) ? PH_PAYLOAD : PH_TAIL;
                    end
                end
                else
                begin
                    bitbuf_next = BUF_W'(pushed);
                    held_next   = cnt[3:0];
                end
            end
            PH_PAYLOAD:
            begin
                r.kind = KIND_PAY;
                r.pay  = in_byte;
                have   = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (in_last)
        begin
            if (phase_next inside {PH_AMD_HDR, PH_AMC_HDR, PH_UM10_HDR, PH_EXT, PH_NACK})
            begin
                r      = '0;
                r.kind = KIND_TRUNC;
            end
            else if (!have)
            begin
                r.kind = KIND_END;
            end
            r.eop       = 1'b1;
            have        = 1'b1;
            phase_next  = PH_IDLE;
            bitbuf_next = '0;
            held_next   = '0;
            hold_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_AM;
            phase_reg  <= PH_IDLE;
            bitbuf_reg <= '0;
            held_reg   <= '0;
            hold_reg   <= '0;
        end
        else if (cfg_we)
        begin
            mode_reg   <= mode_t'(cfg_data);
            phase_reg  <= PH_IDLE;
            bitbuf_reg <= '0;
            held_reg   <= '0;
            hold_reg   <= '0;
        end
        else if (in_accept)
        begin
            phase_reg  <= phase_next;
            bitbuf_reg <= bitbuf_next;
            held_reg   <= held_next;
            hold_reg   <= hold_next;
        end
    end

    assign rec_valid = in_accept && have;
    assign rec       = r;

`ifndef SYNTH
    a_held_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == 4'd0) || (held_reg == 4'd1) || (held_reg == 4'd4) ||
        (held_reg == 4'd5) || (held_reg == 4'd8) || (held_reg == 4'd9))
        else $error("bit count left an unexpected residue");
    a_buf_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (bitbuf_reg >> held_reg) == '0)
        else $error("bit buffer holds bits above the held count");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_last && !cfg_we) |=> (phase_reg == PH_IDLE))
        else $error("parse did not return to idle after the last word");
`endif

endmodule

/* design/rlcph_queue.sv */
// Short record queue between the parsing front end and the output stage.
module rlcph_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rlcph_pkg::rec_t     push_rec,
    input  logic                pop,
    output rlcph_pkg::rec_t     head_rec,
    output logic                empty,
    output logic                full
);
    import rlcph_pkg::*;

    rec_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_rec = mem[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("record pushed into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("record popped from an empty queue");
`endif

endmodule

/* design/rlcph_back.sv */
// Output stage: drains the record queue into a registered output word.
module rlcph_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rlcph_pkg::rec_t         head_rec,
    input  logic                    q_empty,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [rlcph_pkg::TDATA_W-1:0] out_data,
    output logic                    out_last,
    output logic [2:0]              out_kind
);
    import rlcph_pkg::*;

    rec_t   out_reg;
    logic   valid_reg, valid_next;

    assign pop        = !q_empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= head_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign out_valid = valid_reg;
    assign out_last  = out_reg.eop;
    assign out_kind  = out_reg.kind;
    assign out_data  = {4'd0, out_reg.pay, out_reg.ssn, out_reg.li, out_reg.poll,
                        out_reg.rf, out_reg.ext, out_reg.fi, out_reg.sn};

endmodule

/* design/rlc_pdu_header_parser.sv */
// Top level of the radio link control PDU header parser.
//
// The parser takes one PDU byte per word on the s_axis side, most significant
// bit first, with s_axis_tlast on the final byte of the PDU. It decodes the PDU
// according to pdu_mode (0 acknowledged, 1 unacknowledged with a 5-bit SN,
// 2 unacknowledged with a 10-bit SN, 3 transparent) and returns at most one
// record per input word on the m_axis side: a data header, an 11-bit length
// indicator, the ACK_SN or a NACK_SN of a status PDU, a payload byte, or an end
// or truncation record that closes the PDU. The record kind travels in
// m_axis_tuser and m_axis_tlast marks the record caused by the last byte.
// Input words that complete no field produce no output word. Throughput is one
// input word per clock cycle, sustained for as long as the output side keeps
// taking words; the parse state machine decides each byte combinationally.
// The clock edge that accepts a byte also writes its record into the
// four-entry record queue, from which it moves into the output register
// when that register is empty or being taken, and from there onto m_axis.
// The queue absorbs output stalls, and s_axis_tready drops only when it is
// full. Writing the mode register (cfg_we with cfg_data) abandons any PDU in
// progress without a record; write it only while the parser is idle.
module rlc_pdu_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,        // pdu_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] pdu_byte
    input  logic        s_axis_tlast,    // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [9:0] sequence_number, [11:10] framing_info, [12] extension_flag,
    // [13] resegment_flag, [14] poll_flag, [25:15] length_value,
    // [35:26] status_sn, [43:36] payload, [47:44] zero
    output logic [rlcph_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast,    // end_of_pdu
    output logic [2:0]  m_axis_tuser     // [2:0] kind
);
    import rlcph_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   in_accept;
    rec_t   front_rec;
    rec_t   head_rec;
    logic   q_empty;
    logic   pop;

    // A word is taken whenever the queue has room for its possible record.
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    rlcph_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .rec_valid (q_push),
        .rec       (front_rec)
    );

    rlcph_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (front_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .empty    (q_empty),
        .full     (q_full)
    );

    rlcph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_rec  (head_rec),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_kind  (m_axis_tuser)
    );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the radio link control PDU header parser.
`timescale 1ns / 100ps

module testbench;

    import rlcph_pkg::*;

    // Rows of the directed script: a PDU byte to send, or a mode register write.
    typedef enum logic {
        ROW_BYTE,
        ROW_MODE
    } row_op_t;

    typedef struct {
        row_op_t    op;
        logic [7:0] data;
        bit         last;
        bit         typed;
        rec_t       want;
    } row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tlast;
    logic [2:0]           m_axis_tuser;

    // Parser state as this bench predicts it, updated once per accepted input word.
    mode_t                pmode = MODE_AM;
    phase_t               ph = PH_IDLE;
    logic [23:0]          bitbuf = '0;
    int                   nbits = 0;
    bit                   more = 1'b0;
    bit                   odd = 1'b0;
    logic [7:0]           held_byte = '0;

    rec_t                 pending_records[$];
    row_t                 script[$];
    logic [7:0]           pdu_bytes[$];
    bit                   bitq[$];

    int                   mismatches = 0;
    int                   bytes_sent = 0;
    int                   records_seen = 0;
    int                   kind_seen[7];
    int                   tx_idle_pct = 0;
    int                   rx_stall_pct = 0;
    bit                   hold_req = 1'b0;
    int                   hold_left = 0;

    rlc_pdu_header_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Drop back to waiting for the first byte of a PDU.
    function automatic void clear_parse();
        ph = PH_IDLE;
        bitbuf = '0;
        nbits = 0;
        more = 1'b0;
        odd = 1'b0;
        held_byte = '0;
    endfunction

    // After a data header: either length indicator groups follow or payload does.
    function automatic void open_groups(bit e);
        bitbuf = '0;
        nbits = 0;
        odd = 1'b0;
        more = e;
        ph = e ? PH_EXT : PH_PAYLOAD;
    endfunction

    // Predicts the record, if any, that one accepted PDU byte produces.
    task automatic parse_byte(input logic [7:0] b, input bit l, output bit has, output rec_t r);
        logic [15:0] w;
        logic [11:0] g;
        r = '0;
        has = 1'b0;
        w = {held_byte, b};
        case (ph)
            PH_IDLE:
                case (pmode)
                    MODE_AM:
                    begin
                        held_byte = b;
                        ph = b[7] ? PH_AMD_HDR : PH_AMC_HDR;
                    end
                    MODE_UM5:
                    begin
                        r.kind = KIND_HDR;
                        r.sn = {5'd0, b[4:0]};
                        r.fi = b[7:6];
                        r.ext = b[5];
                        has = 1'b1;
                        open_groups(b[5]);
                    end
                    MODE_UM10:
                    begin
                        held_byte = b;
                        ph = PH_UM10_HDR;
                    end
                    default:
                    begin
                        r.kind = KIND_PAY;
                        r.pay = b;
                        has = 1'b1;
                        ph = PH_PAYLOAD;
                    end
                endcase
            PH_AMD_HDR, PH_UM10_HDR:
            begin
                r.kind = KIND_HDR;
                r.sn = w[9:0];
                r.fi = w[12:11];
                r.ext = w[10];
                // RF and poll exist only in the acknowledged data header.
                if (ph == PH_AMD_HDR)
                begin
                    r.rf = w[14];
                    r.poll = w[13];
                end
                has = 1'b1;
                open_groups(w[10]);
            end
            PH_AMC_HDR:
            begin
                r.kind = KIND_ACK;
                r.ssn = w[11:2];
                has = 1'b1;
                // Bit 0 is already the first bit of the first NACK group.
                bitbuf = {23'd0, w[0]};
                nbits = 1;
                more = w[1];
                ph = more ? PH_NACK : PH_TAIL;
            end
            PH_EXT, PH_NACK:
            begin
                bitbuf = {bitbuf[15:0], b};
                nbits += 8;
                if (nbits >= 12)
                begin
                    g = 12'(bitbuf >> (nbits - 12));
                    nbits -= 12;
                    bitbuf &= (24'd1 << nbits) - 24'd1;
                    has = 1'b1;
                    if (ph == PH_EXT)
                    begin
                        r.kind = KIND_LI;
                        r.li = g[10:0];
                        odd = ~odd;
                        more = g[11];
                        // Whatever is left is the pad after an odd group count.
                        if (!more)
                        begin
                            bitbuf = '0;
                            nbits = 0;
                            ph = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        r.kind = KIND_NACK;
                        r.ssn = g[11:2];
                        more = g[1];
                        if (!more)
                        begin
                            bitbuf = '0;
                            nbits = 0;
                            ph = PH_TAIL;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                r.kind = KIND_PAY;
                r.pay = b;
                has = 1'b1;
            end
            default:
                ;
        endcase
        // The last byte either truncates an unfinished header or group, or closes the PDU.
        if (l)
        begin
            if (ph >= PH_AMD_HDR && ph <= PH_NACK)
            begin
                r = '0;
                r.kind = KIND_TRUNC;
            end
            else if (!has)
                r.kind = KIND_END;
            r.eop = 1'b1;
            has = 1'b1;
            clear_parse();
        end
    endtask

    function automatic rec_t rec_of(kind_t k, bit eop, int sn = 0, int fi = 0, int e = 0,
                                    int rf = 0, int p = 0, int li = 0, int ssn = 0,
                                    int pay = 0);
        rec_t r;
        r = '0;
        r.kind = k;
        r.eop = eop;
        r.sn = sn[9:0];
        r.fi = fi[1:0];
        r.ext = e[0];
        r.rf = rf[0];
        r.poll = p[0];
        r.li = li[10:0];
        r.ssn = ssn[9:0];
        r.pay = pay[7:0];
        return r;
    endfunction

    function automatic void add_row(row_op_t op, logic [7:0] d, bit l = 1'b0, bit t = 1'b0,
                                    rec_t w = '0);
        row_t row;
        row.op = op;
        row.data = d;
        row.last = l;
        row.typed = t;
        row.want = w;
        script.insert(script.size(), row);
    endfunction

    // Offers one word on the input side after a random gap, waits for the handshake
    // and records what the parser should return for it. A typed expectation, where
    // given, replaces the predicted one.
    task automatic send_byte(input logic [7:0] b, input bit l, input bit typed, input rec_t want);
        int   gap;
        bit   ready_seen;
        bit   has;
        rec_t got;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= l;
        // Sample ready mid-cycle; the word is taken at the edge that follows.
        do
        begin
            @(negedge clk);
            ready_seen = s_axis_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        parse_byte(b, l, has, got);
        if (typed)
        begin
            has = 1'b1;
            got = want;
        end
        if (has)
            pending_records.insert(pending_records.size(), got);
        bytes_sent++;
    endtask

    // Stops offering words and waits until every expected record has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_records.size() != 0)
            @(posedge clk);
    endtask

    // Mode writes happen only with the parser drained; a byte that makes no record
    // may still be in flight, so the clock runs on a while before the write.
    task automatic write_mode(mode_t m);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        pmode = m;
        clear_parse();
    endtask

    // Field values biased toward all zeros and all ones.
    function automatic int unsigned rand_field(int bits);
        int unsigned ones;
        ones = (32'd1 << bits) - 1;
        case ($urandom_range(7))
            0: return 0;
            1: return ones;
            default: return $urandom & ones;
        endcase
    endfunction

    function automatic void put_bits(int n, int unsigned v);
        for (int i = n - 1; i >= 0; i--)
            bitq.insert(bitq.size(), v[i]);
    endfunction

    // Extension part: E(1) LI(11) groups, the final one with E clear.
    function automatic void add_length_groups();
        int groups;
        groups = $urandom_range(1, ($urandom_range(7) == 0) ? 8 : 3);
        for (int i = 0; i < groups; i++)
        begin
            put_bits(1, i < groups - 1);
            put_bits(11, rand_field(11));
        end
    endfunction

    // Builds one well-formed PDU for the given mode into pdu_bytes.
    task automatic build_pdu(mode_t m);
        int         groups;
        bit         e;
        logic [7:0] val;
        bitq.delete();
        pdu_bytes.delete();
        e = $urandom_range(1);
        case (m)
            MODE_AM:
                if ($urandom_range(1))
                begin
                    put_bits(1, 1);
                    put_bits(2, $urandom_range(3));
                    put_bits(2, $urandom_range(3));
                    put_bits(1, e);
                    put_bits(10, rand_field(10));
                    if (e)
                        add_length_groups();
                end
                else
                begin
                    // Status PDU: D/C, CPT, ACK_SN, E1, then NACK_SN E1 E2 groups.
                    put_bits(1, 0);
                    put_bits(3, $urandom_range(7));
                    put_bits(10, rand_field(10));
                    groups = $urandom_range(1) ? $urandom_range(1, 4) : 0;
                    put_bits(1, groups != 0);
                    for (int i = 0; i < groups; i++)
                    begin
                        put_bits(10, rand_field(10));
                        put_bits(1, i < groups - 1);
                        put_bits(1, $urandom_range(1));
                    end
                end
            MODE_UM5:
            begin
                put_bits(2, $urandom_range(3));
                put_bits(1, e);
                put_bits(5, rand_field(5));
                if (e)
                    add_length_groups();
            end
            MODE_UM10:
            begin
                put_bits(3, $urandom_range(7));
                put_bits(2, $urandom_range(3));
                put_bits(1, e);
                put_bits(10, rand_field(10));
                if (e)
                    add_length_groups();
            end
            default:
                repeat ($urandom_range(1, 5)) pdu_bytes.insert(pdu_bytes.size(), 8'($urandom));
        endcase
        // Random fill up to a byte boundary stands in for pad bits.
        while (bitq.size() % 8 != 0)
            bitq.insert(bitq.size(), 1'($urandom_range(1)));
        for (int i = 0; i < bitq.size(); i += 8)
        begin
            val = '0;
            for (int j = 0; j < 8; j++)
                val = {val[6:0], bitq[i + j]};
            pdu_bytes.insert(pdu_bytes.size(), val);
        end
        // Payload after a data header, ignored tail bytes after a status PDU.
        if (m != MODE_TM)
            repeat ($urandom_range(0, 3)) pdu_bytes.insert(pdu_bytes.size(), 8'($urandom));
    endtask

    // Mostly well-formed PDUs; the rest are cut short (with or without a last
    // flag, leaving the parser mid-PDU) or plain noise.
    task automatic send_random_pdu();
        int  pick;
        int  stop;
        int  n;
        bit  keep_last;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom), $urandom_range(3) == 0, 1'b0, '0);
        end
        else
        begin
            build_pdu(pmode);
            stop = pdu_bytes.size();
            if (pick < 22)
                stop = $urandom_range(1, stop);
            keep_last = !(pick >= 16 && pick < 22);
            for (int i = 0; i < stop; i++)
                send_byte(pdu_bytes[i], keep_last && (i == stop - 1), 1'b0, '0);
        end
    endtask

    // Output side: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 200;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Output words are sampled mid-cycle and taken at the following edge.
    always @(negedge clk)
    begin : record_check
        rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            records_seen++;
            if (m_axis_tuser <= 3'd6)
                kind_seen[m_axis_tuser]++;
            if (pending_records.size() == 0)
            begin
                $error("record of kind %0d with none expected", m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_records.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("end_of_pdu", want.eop, m_axis_tlast);
                check_field("sequence_number", want.sn, m_axis_tdata[9:0]);
                check_field("framing_info", want.fi, m_axis_tdata[11:10]);
                check_field("extension_flag", want.ext, m_axis_tdata[12]);
                check_field("resegment_flag", want.rf, m_axis_tdata[13]);
                check_field("poll_flag", want.poll, m_axis_tdata[14]);
                check_field("length_value", want.li, m_axis_tdata[25:15]);
                check_field("status_sn", want.ssn, m_axis_tdata[35:26]);
                check_field("payload", want.pay, m_axis_tdata[43:36]);
            end
        end
    end

    initial
    begin
        // Directed script. The parser comes out of reset in acknowledged mode.
        // AM data header with every bit set, two length indicators, one payload byte.
        add_row(ROW_BYTE, 8'hFF);
        add_row(ROW_BYTE, 8'hFF, 1'b0, 1'b1,
                rec_of(KIND_HDR, 1'b0, 10'h3FF, 3, 1, 1, 1));
        add_row(ROW_BYTE, 8'hFF);
        add_row(ROW_BYTE, 8'hF0);
        add_row(ROW_BYTE, 8'h00);
        add_row(ROW_BYTE, 8'hA5, 1'b1, 1'b1, rec_of(KIND_PAY, 1'b1, .pay(8'hA5)));
        // Status PDU: largest ACK_SN, one NACK group closing on the last byte.
        add_row(ROW_BYTE, 8'h0F);
        add_row(ROW_BYTE, 8'hFF);
        add_row(ROW_BYTE, 8'h00);
        add_row(ROW_BYTE, 8'h00, 1'b1);
        // Data PDU cut off inside its header.
        add_row(ROW_BYTE, 8'h80, 1'b1, 1'b1, rec_of(KIND_TRUNC, 1'b1));
        // Status PDU without NACKs; the byte after it only closes the PDU.
        add_row(ROW_BYTE, 8'h00);
        add_row(ROW_BYTE, 8'h00, 1'b0, 1'b1, rec_of(KIND_ACK, 1'b0));
        add_row(ROW_BYTE, 8'h55, 1'b1, 1'b1, rec_of(KIND_END, 1'b1));
        // UM 5-bit SN: a one-byte PDU, then a length indicator that completes on a
        // last byte while another group is still announced.
        add_row(ROW_MODE, MODE_UM5);
        add_row(ROW_BYTE, 8'h00, 1'b1, 1'b1, rec_of(KIND_HDR, 1'b1));
        add_row(ROW_BYTE, 8'hFF, 1'b0, 1'b1, rec_of(KIND_HDR, 1'b0, 31, 3, 1));
        add_row(ROW_BYTE, 8'hFF);
        add_row(ROW_BYTE, 8'hF0, 1'b1, 1'b1, rec_of(KIND_TRUNC, 1'b1));
        // UM 10-bit SN, truncated inside the extension part, then a PDU left
        // half-parsed for the next mode write to abandon.
        add_row(ROW_MODE, MODE_UM10);
        add_row(ROW_BYTE, 8'hFF);
        add_row(ROW_BYTE, 8'hFF, 1'b0, 1'b1, rec_of(KIND_HDR, 1'b0, 10'h3FF, 3, 1));
        add_row(ROW_BYTE, 8'h00, 1'b1, 1'b1, rec_of(KIND_TRUNC, 1'b1));
        add_row(ROW_BYTE, 8'h12);
        add_row(ROW_MODE, MODE_TM);
        add_row(ROW_BYTE, 8'hFF, 1'b0, 1'b1, rec_of(KIND_PAY, 1'b0, .pay(8'hFF)));
        add_row(ROW_BYTE, 8'h00, 1'b1, 1'b1, rec_of(KIND_PAY, 1'b1));
        add_row(ROW_MODE, MODE_AM);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].op == ROW_MODE)
                write_mode(mode_t'(script[i].data[1:0]));
            else
                send_byte(script[i].data, script[i].last, script[i].typed, script[i].want);
        end

        // Random part: four idling profiles, each visiting every mode once.
        for (int ip = 0; ip < 4; ip++)
        begin
            tx_idle_pct = (ip == 1 || ip == 3) ? ((ip == 1) ? 64 : 17) : 0;
            rx_stall_pct = (ip == 2 || ip == 3) ? ((ip == 2) ? 64 : 17) : 0;
            for (int blk = 0; blk < 4; blk++)
            begin
                int  target;
                bit  pause_due;
                write_mode(mode_t'((ip + blk) % 4));
                target = bytes_sent + 38;
                // Transparent mode with no idling: hold the output off long enough
                // for the record queue to fill and back-pressure the input.
                if (ip == 0 && blk == 3)
                    hold_req = 1'b1;
                pause_due = (ip == 1 && blk == 2);
                while (bytes_sent < target)
                begin
                    send_random_pdu();
                    if (pause_due && bytes_sent >= target - 20)
                    begin
                        wait_drained();
                        pause_due = 1'b0;
                    end
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Sent %0d PDU bytes across all four modes and checked %0d records:",
                 bytes_sent, records_seen);
        $display("  %0d headers, %0d LIs, %0d ACK/NACK SNs, %0d payload, %0d end/truncated.",
                 kind_seen[KIND_HDR], kind_seen[KIND_LI],
                 kind_seen[KIND_ACK] + kind_seen[KIND_NACK], kind_seen[KIND_PAY],
                 kind_seen[KIND_END] + kind_seen[KIND_TRUNC]);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* rlc_pdu_header_parser.f */
design/rlcph_pkg.sv
design/rlcph_front.sv
design/rlcph_queue.sv
design/rlcph_back.sv
design/rlc_pdu_header_parser.sv
dv/testbench.sv
